[sv/assert_macros.svh]
// assertion helpers used by the responder core
// both expect clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies another in the next cycle
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[sv/t4t_pkg.sv]
`default_nettype none

package t4t_pkg;

    // fixed field widths
    localparam int CNT_W = 11;
    localparam int LEN_W = 13;

    // input opcodes
    localparam logic [1:0] OP_APDU     = 2'd0;
    localparam logic [1:0] OP_HOST_WR  = 2'd1;
    localparam logic [1:0] OP_ACTIVATE = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_READ_ONLY = 3'd0;
    localparam logic [2:0] REG_CAPACITY  = 3'd1;
    localparam logic [2:0] REG_INIT_LEN  = 3'd2;
    localparam logic [2:0] REG_CC_LOW    = 3'd3;
    localparam logic [2:0] REG_CC_HIGH   = 3'd4;

    // instruction codes and file ids
    localparam logic [7:0]  INS_SELECT = 8'hA4;
    localparam logic [7:0]  INS_READ   = 8'hB0;
    localparam logic [7:0]  INS_UPDATE = 8'hD6;
    localparam logic [7:0]  P1_BY_NAME = 8'h04;
    localparam logic [7:0]  P1_BY_ID   = 8'h00;
    localparam logic [15:0] FID_CC     = 16'hE103;
    localparam logic [15:0] FID_NDEF   = 16'hE104;

    // selected file codes
    localparam logic [1:0] SEL_NONE = 2'd0;
    localparam logic [1:0] SEL_CC   = 2'd1;
    localparam logic [1:0] SEL_NDEF = 2'd2;

    // status words
    localparam logic [15:0] SW_OK          = 16'h9000;
    localparam logic [15:0] SW_BAD_OFFSET  = 16'h6A86;
    localparam logic [15:0] SW_NOT_FOUND   = 16'h6A82;
    localparam logic [15:0] SW_NO_SPACE    = 16'h6A84;
    localparam logic [15:0] SW_NOT_ALLOWED = 16'h6985;
    localparam logic [15:0] SW_NO_FILE     = 16'h6986;
    localparam logic [15:0] SW_BAD_LENGTH  = 16'h6700;
    localparam logic [15:0] SW_BAD_INS     = 16'h6D00;

    // NDEF application id
    localparam logic [55:0] AID = 56'hD2760000850101;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [11:0] host_address;
    } in_t;

    typedef struct packed {
        logic [63:0]      response_bytes;
        logic [3:0]       byte_count;
        logic             last_beat;
        logic [15:0]      status_word;
        logic             committed;
        logic [LEN_W-1:0] committed_length;
    } out_t;

    typedef enum logic [1:0] {
        ACT_RESP   = 2'd0,
        ACT_READ   = 2'd1,
        ACT_UPDATE = 2'd2
    } act_t;

    // command decision handed to the sequencer
    typedef struct packed {
        act_t             act;
        logic [15:0]      sw;
        logic             sel_we;
        logic [1:0]       sel_new;
        logic [15:0]      off;
        logic [8:0]       take;
        logic [7:0]       lc;
        logic [LEN_W-1:0] nlen;
        logic             touched;
    } dec_t;

    // capability container byte, index 0 to 14
    function automatic logic [7:0] cc_byte(input logic [63:0] lo, input logic [55:0] hi,
                                           input logic [3:0] idx);
        logic [119:0] v;
        logic [119:0] s;
        v = {lo, hi};
        s = v >> (8 * (14 - int'(idx)));
        return (idx < 4'd15) ? s[7:0] : 8'd0;
    endfunction

endpackage

`default_nettype wire

[sv/t4t_decode.sv]
`default_nettype none

module t4t_decode (
    input  wire logic [11:0][7:0]          hdr,
    input  wire logic [t4t_pkg::CNT_W-1:0] n,
    input  wire logic [1:0]                sel,
    input  wire logic                      read_only,
    input  wire logic [t4t_pkg::LEN_W-1:0] capacity,
    input  wire logic [t4t_pkg::LEN_W-1:0] msg_len,
    output t4t_pkg::dec_t                  dec
);
    import t4t_pkg::*;

    logic [15:0] off;
    logic [8:0]  le;
    logic [16:0] fsize;
    logic [16:0] remain;
    logic [7:0]  lc;
    logic [16:0] end_pos;
    logic        cap_err;
    logic [15:0] nlen;
    logic        touched;
    logic [15:0] fid;

    // common fields
    always_comb
    begin
        off     = {hdr[2], hdr[3]};
        lc      = hdr[4];
        fid     = {hdr[5], hdr[6]};
        le      = (n >= 11'd5 && hdr[4] != 8'd0) ? {1'b0, hdr[4]} : 9'd256;
        fsize   = (sel == SEL_CC) ? 17'd15 : 17'(msg_len) + 17'd2;
        remain  = fsize - 17'(off);
        end_pos = 17'(off) + 17'(lc) - 17'd1;
        cap_err = (end_pos >= 17'd2) && ((end_pos - 17'd2) >= 17'(capacity));
        touched = (off < 16'd2);
        nlen    = 16'(msg_len);
        if (off == 16'd0)
        begin
            nlen[15:8] = hdr[5];
            if (lc >= 8'd2)
            begin
                nlen[7:0] = hdr[6];
            end
        end
        else if (off == 16'd1)
        begin
            nlen[7:0] = hdr[5];
        end
    end

    // command decision
    always_comb
    begin
        dec         = '0;
        dec.act     = ACT_RESP;
        dec.off     = off;
        dec.lc      = lc;
        dec.nlen    = nlen[LEN_W-1:0];
        dec.touched = touched;
        dec.sw      = SW_BAD_INS;
        if (n < 11'd4)
        begin
            dec.sw = SW_BAD_LENGTH;
        end
        else if (hdr[1] == INS_SELECT && hdr[2] == P1_BY_NAME)
        begin
            if (n >= 11'd12 && hdr[4] == 8'h07 && {hdr[5], hdr[6], hdr[7], hdr[8], hdr[9],
                hdr[10], hdr[11]} == AID)
            begin
                dec.sw      = SW_OK;
                dec.sel_we  = 1'b1;
                dec.sel_new = SEL_NONE;
            end
            else
            begin
                dec.sw = SW_NOT_FOUND;
            end
        end
        else if (hdr[1] == INS_SELECT && hdr[2] == P1_BY_ID)
        begin
            dec.sw = SW_NOT_FOUND;
            if (n >= 11'd7 && hdr[4] == 8'h02 && fid == FID_CC)
            begin
                dec.sw      = SW_OK;
                dec.sel_we  = 1'b1;
                dec.sel_new = SEL_CC;
            end
            else if (n >= 11'd7 && hdr[4] == 8'h02 && fid == FID_NDEF)
            begin
                dec.sw      = SW_OK;
                dec.sel_we  = 1'b1;
                dec.sel_new = SEL_NDEF;
            end
        end
        else if (hdr[1] == INS_READ)
        begin
            if (sel != SEL_CC && sel != SEL_NDEF)
            begin
                dec.sw = SW_NO_FILE;
            end
            else if (17'(off) >= fsize)
            begin
                dec.sw = SW_BAD_OFFSET;
            end
            else
            begin
                dec.sw   = SW_OK;
                dec.act  = ACT_READ;
                dec.take = (remain > 17'(le)) ? le : remain[8:0];
            end
        end
        else if (hdr[1] == INS_UPDATE)
        begin
            if (read_only)
            begin
                dec.sw = SW_NOT_ALLOWED;
            end
            else if (sel != SEL_NDEF)
            begin
                dec.sw = SW_NO_FILE;
            end
            else if (n < 11'd5 || lc == 8'd0 || 12'(n) < 12'd5 + 12'(lc))
            begin
                dec.sw = SW_BAD_LENGTH;
            end
            else if (cap_err || (touched && nlen > 16'(capacity)))
            begin
                dec.sw = SW_NO_SPACE;
            end
            else
            begin
                dec.sw  = SW_OK;
                dec.act = ACT_UPDATE;
            end
        end
    end

endmodule

`default_nettype wire

[sv/type4_tag_apdu_responder_core.sv]
`default_nettype none
// Type 4 tag responder core.
// Input channel (in_valid/in_ready, in_data): APDU bytes with a last mark,
// host writes into the message store, and reader activation.
// Output channel (out_valid/out_ready, out_data): R-APDU beats of up to eight
// bytes, first byte in the top bits, status and commit info on the last beat.
// Configuration (cfg_write/cfg_index/cfg_data) is a plain write port, used idle.
// Non-final APDU bytes, host writes and activation are taken in idle, which stays ready for the next item.
// After the last APDU byte the header is fetched from the APDU memory (S_HDR),
// decoded (S_DEC), then an UPDATE walks its data bytes one per cycle through
// the message memory write port (S_WR).
// Each response byte is then read from the message memory (S_ISSUE) and
// captured (S_CAPT), and each beat is loaded into the output register (S_EMIT).
// The input is held off until the final beat is in the output register.
// A stalled receiver holds the beat in the output register and stops the walk.
// Reset clears selection, length, configuration, counters and control registers;
// the payload registers and the memories keep their contents and need no clearing pass.
`include "assert_macros.svh"

module type4_tag_apdu_responder_core #(
    parameter int NDEF_BYTES = 4096,
    parameter int APDU_BYTES = 512
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire t4t_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output t4t_pkg::out_t      out_data,
    input  wire logic          cfg_write,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [63:0]   cfg_data
);
    import t4t_pkg::*;

    localparam int AW = $clog2(APDU_BYTES);
    localparam int CW = $clog2(APDU_BYTES + 1);
    localparam int MW = $clog2(NDEF_BYTES);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_HDR   = 7'b0000010,
        S_DEC   = 7'b0000100,
        S_WR    = 7'b0001000,
        S_ISSUE = 7'b0010000,
        S_CAPT  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [1:0]       sel_reg, sel_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ro_reg, ro_next;
    logic [LEN_W-1:0] cap_reg, cap_next;
    logic [63:0]      cc_lo_reg, cc_lo_next;
    logic [55:0]      cc_hi_reg, cc_hi_next;

    logic [11:0][7:0] hdr_reg, hdr_next;
    logic [3:0]       hcnt_reg, hcnt_next;

    logic [15:0]      off_reg, off_next;
    logic [8:0]       take_reg, take_next;
    logic [7:0]       lc_reg, lc_next;
    logic [LEN_W-1:0] nlen_reg, nlen_next;
    logic             touched_reg, touched_next;
    logic [15:0]      sw_reg, sw_next;
    logic             commit_reg, commit_next;

    logic [7:0]       wi_reg, wi_next;
    logic             wpend_reg, wpend_next;
    logic [16:0]      wpos_reg, wpos_next;

    logic [8:0]       j_reg, j_next;
    logic [63:0]      pk_reg, pk_next;
    logic [3:0]       pcnt_reg, pcnt_next;

    logic             out_valid_reg, out_valid_next;
    out_t             out_reg, out_next;

    // memories and their ports
    logic [7:0]    apdu_mem [APDU_BYTES];
    logic [7:0]    msg_mem [NDEF_BYTES];
    logic          apdu_we;
    logic [AW-1:0] apdu_waddr;
    logic [AW-1:0] apdu_raddr;
    logic [7:0]    apdu_rdata_reg;
    logic          msg_we;
    logic [MW-1:0] msg_waddr;
    logic [7:0]    msg_wdata;
    logic [MW-1:0] msg_raddr;
    logic [7:0]    msg_rdata_reg;

    dec_t        dec;
    logic [8:0]  total;
    logic [16:0] pos;
    logic [7:0]  rbyte;
    logic        out_load;
    logic        final_beat;
    logic        in_acc;
    logic [LEN_W-1:0] cap_clamp;

    // command decoder
    t4t_decode u_decode (
        .hdr       (hdr_reg),
        .n         (n_reg),
        .sel       (sel_reg),
        .read_only (ro_reg),
        .capacity  (cap_reg),
        .msg_len   (len_reg),
        .dec       (dec)
    );

    // apdu memory
    always_ff @(posedge clk)
    begin
        if (apdu_we)
        begin
            apdu_mem[apdu_waddr] <= in_data.data_byte;
        end
        apdu_rdata_reg <= apdu_mem[apdu_raddr];
    end

    // message memory
    always_ff @(posedge clk)
    begin
        if (msg_we)
        begin
            msg_mem[msg_waddr] <= msg_wdata;
        end
        msg_rdata_reg <= msg_mem[msg_raddr];
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign total     = take_reg + 9'd2;
    assign pos       = 17'(off_reg) + 17'(j_reg);
    assign out_load  = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);
    assign final_beat = (j_reg == total);
    assign cap_clamp = (17'(cfg_data[12:0]) > 17'(NDEF_BYTES)) ?
                       LEN_W'(NDEF_BYTES) : cfg_data[12:0];

    // response byte source
    always_comb
    begin
        if (j_reg < take_reg)
        begin
            if (sel_reg == SEL_CC)
            begin
                rbyte = cc_byte(cc_lo_reg, cc_hi_reg, pos[3:0]);
            end
            else if (pos == 17'd0)
            begin
                rbyte = 8'(len_reg >> 8);
            end
            else if (pos == 17'd1)
            begin
                rbyte = len_reg[7:0];
            end
            else
            begin
                rbyte = msg_rdata_reg;
            end
        end
        else if (j_reg == take_reg)
        begin
            rbyte = sw_reg[15:8];
        end
        else
        begin
            rbyte = sw_reg[7:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        sel_next       = sel_reg;
        len_next       = len_reg;
        ro_next        = ro_reg;
        cap_next       = cap_reg;
        cc_lo_next     = cc_lo_reg;
        cc_hi_next     = cc_hi_reg;
        hdr_next       = hdr_reg;
        hcnt_next      = hcnt_reg;
        off_next       = off_reg;
        take_next      = take_reg;
        lc_next        = lc_reg;
        nlen_next      = nlen_reg;
        touched_next   = touched_reg;
        sw_next        = sw_reg;
        commit_next    = commit_reg;
        wi_next        = wi_reg;
        wpend_next     = wpend_reg;
        wpos_next      = wpos_reg;
        j_next         = j_reg;
        pk_next        = pk_reg;
        pcnt_next      = pcnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        apdu_we        = 1'b0;
        apdu_waddr     = cnt_reg[AW-1:0];
        apdu_raddr     = AW'(hcnt_reg);
        msg_we         = 1'b0;
        msg_waddr      = in_data.host_address[MW-1:0];
        msg_wdata      = in_data.data_byte;
        msg_raddr      = MW'(pos - 17'd2);

        // output register drains
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_data.opcode)
                        OP_HOST_WR:
                        begin
                            msg_we = (32'(in_data.host_address) < NDEF_BYTES);
                        end
                        OP_ACTIVATE:
                        begin
                            sel_next = SEL_NONE;
                            cnt_next = '0;
                        end
                        OP_APDU:
                        begin
                            if (cnt_reg < CW'(APDU_BYTES))
                            begin
                                apdu_we  = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                            if (in_data.last_byte)
                            begin
                                n_next     = CNT_W'(cnt_next);
                                cnt_next   = '0;
                                hcnt_next  = '0;
                                state_next = S_HDR;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_HDR:
            begin
                // header bytes arrive in the cycle after their address
                if (hcnt_reg != 4'd0)
                begin
                    hdr_next[hcnt_reg - 4'd1] = apdu_rdata_reg;
                end
                hcnt_next = hcnt_reg + 4'd1;
                if (hcnt_reg == 4'd12)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                off_next     = dec.off;
                take_next    = dec.take;
                lc_next      = dec.lc;
                nlen_next    = dec.nlen;
                touched_next = dec.touched;
                sw_next      = dec.sw;
                commit_next  = 1'b0;
                j_next       = '0;
                pk_next      = '0;
                pcnt_next    = '0;
                wi_next      = '0;
                wpend_next   = 1'b0;
                if (dec.sel_we)
                begin
                    sel_next = dec.sel_new;
                end
                state_next = (dec.act == ACT_UPDATE) ? S_WR : S_ISSUE;
            end
            S_WR:
            begin
                // write the byte fetched in the previous cycle
                if (wpend_reg)
                begin
                    msg_we    = (wpos_reg >= 17'd2) &&
                                (32'(wpos_reg - 17'd2) < NDEF_BYTES);
                    msg_waddr = MW'(wpos_reg - 17'd2);
                    msg_wdata = apdu_rdata_reg;
                end
                if (wi_reg < lc_reg)
                begin
                    apdu_raddr = AW'({1'b0, wi_reg} + 9'd5);
                    wpend_next = 1'b1;
                    wpos_next  = 17'(off_reg) + 17'(wi_reg);
                    wi_next    = wi_reg + 8'd1;
                end
                else
                begin
                    wpend_next = 1'b0;
                    if (!wpend_reg)
                    begin
                        if (touched_reg)
                        begin
                            len_next = nlen_reg;
                        end
                        commit_next = touched_reg;
                        take_next   = '0;
                        state_next  = S_ISSUE;
                    end
                end
            end
            S_ISSUE:
            begin
                state_next = S_CAPT;
            end
            S_CAPT:
            begin
                pk_next   = pk_reg | (64'(rbyte) << (8 * (7 - int'(pcnt_reg))));
                pcnt_next = pcnt_reg + 4'd1;
                j_next    = j_reg + 9'd1;
                if (pcnt_reg == 4'd7 || j_next == total)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_ISSUE;
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next            = 1'b1;
                    out_next.response_bytes   = pk_reg;
                    out_next.byte_count       = pcnt_reg;
                    out_next.last_beat        = final_beat;
                    out_next.status_word      = final_beat ? sw_reg : 16'd0;
                    out_next.committed        = final_beat && commit_reg;
                    out_next.committed_length = (final_beat && commit_reg) ?
                                                len_reg : '0;
                    pk_next    = '0;
                    pcnt_next  = '0;
                    state_next = final_beat ? S_IDLE : S_ISSUE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // configuration writes
        if (cfg_write)
        begin
            case (cfg_index)
                REG_READ_ONLY:
                begin
                    ro_next = cfg_data[0];
                end
                REG_CAPACITY:
                begin
                    cap_next = cap_clamp;
                    if (len_reg > cap_clamp)
                    begin
                        len_next = cap_clamp;
                    end
                end
                REG_INIT_LEN:
                begin
                    len_next = (cfg_data[12:0] > cap_reg) ? cap_reg : cfg_data[12:0];
                end
                REG_CC_LOW:
                begin
                    cc_lo_next = cfg_data;
                end
                REG_CC_HIGH:
                begin
                    cc_hi_next = cfg_data[55:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // control and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            sel_reg       <= SEL_NONE;
            len_reg       <= '0;
            ro_reg        <= 1'b0;
            cap_reg       <= '0;
            cc_lo_reg     <= '0;
            cc_hi_reg     <= '0;
            hcnt_reg      <= '0;
            wi_reg        <= '0;
            wpend_reg     <= 1'b0;
            j_reg         <= '0;
            pcnt_reg      <= '0;
            commit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sel_reg       <= sel_next;
            len_reg       <= len_next;
            ro_reg        <= ro_next;
            cap_reg       <= cap_next;
            cc_lo_reg     <= cc_lo_next;
            cc_hi_reg     <= cc_hi_next;
            hcnt_reg      <= hcnt_next;
            wi_reg        <= wi_next;
            wpend_reg     <= wpend_next;
            j_reg         <= j_next;
            pcnt_reg      <= pcnt_next;
            commit_reg    <= commit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        hdr_reg     <= hdr_next;
        off_reg     <= off_next;
        take_reg    <= take_next;
        lc_reg      <= lc_next;
        nlen_reg    <= nlen_next;
        touched_reg <= touched_next;
        sw_reg      <= sw_next;
        wpos_reg    <= wpos_next;
        pk_reg      <= pk_next;
        out_reg     <= out_next;
    end

    // checks
    `ASSERT_NEXT(a_last_to_hdr, in_acc && in_data.opcode == OP_APDU && in_data.last_byte, state_reg == S_HDR, "last APDU byte did not start header fetch")
    `ASSERT_CLK(a_pack_bound, pcnt_reg <= 4'd8, "beat packer overflow")
    `ASSERT_CLK(a_msg_we_state, msg_we |-> (state_reg == S_IDLE || state_reg == S_WR), "message write outside host or update phase")
    `ASSERT_NEXT(a_final_idle, out_load && final_beat, state_reg == S_IDLE && out_valid_reg && out_reg.last_beat, "final beat not followed by idle")

endmodule

`default_nettype wire

[test/tb_type4_tag_apdu_responder_core.sv]
`timescale 1ns / 1ps

module tb_type4_tag_apdu_responder_core;
    import t4t_pkg::*;

    localparam int STORE_BYTES = 4096;
    localparam int CMD_BYTES = 512;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;
    logic cfg_write;
    logic [2:0] cfg_index;
    logic [63:0] cfg_data;

    type4_tag_apdu_responder_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // pending requests and expected response beats
    in_t pending_reqs[$];
    out_t beat_q[$];
    int errors = 0;
    bit idle_on = 1'b1;
    logic press_go = 1'b0;
    int press_cnt = 0;
    int in_gap = 0;
    int out_hold = 0;

    // tag state tracked by the testbench
    bit tag_ro;
    int tag_cap;
    int tag_init_len;
    logic [63:0] cc_lo;
    logic [55:0] cc_hi;
    logic [7:0] msg_mem[STORE_BYTES];
    int msg_len;
    int sel_file;
    logic [7:0] cmd_buf[CMD_BYTES];
    int cmd_n;

    // generation side bookkeeping
    bit written[STORE_BYTES];
    int gen_cap;
    int rand_items = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            in_gap <= 0;
        end
        else if (!(in_valid && !in_ready))
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                in_data <= pending_reqs.pop_front();
                in_valid <= 1'b1;
                in_gap <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver ready, with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_hold <= 0;
        end
        else if (press_go && press_cnt < 400)
        begin
            out_ready <= 1'b0;
            press_cnt <= press_cnt + 1;
        end
        else if (out_hold > 0)
        begin
            out_ready <= 1'b0;
            out_hold <= out_hold - 1;
        end
        else if (idle_on && $urandom_range(0, 99) < 25)
        begin
            out_ready <= 1'b0;
            out_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
        end
        else
            out_ready <= 1'b1;
    end

    function automatic int cmd_byte(int i);
        return (i < CMD_BYTES) ? int'(cmd_buf[i]) : 0;
    endfunction

    function automatic logic [7:0] cap_cont_byte(int i);
        if (i < 8)
            return cc_lo[63 - 8 * i -: 8];
        if (i < 15)
            return cc_hi[55 - 8 * (i - 8) -: 8];
        return 8'h00;
    endfunction

    // answer a complete command into response bytes and status
    task automatic answer_cmd(input int n, inout logic [7:0] resp[$], output logic [15:0] sw,
                              output bit commit);
        int ins;
        int p1;
        int off;
        int le;
        int fsize;
        int take;
        int lc;
        int nlen;
        int p;
        int fid;
        bit touched;
        bit same;
        bit fail;
        commit = 1'b0;
        touched = 1'b0;
        fail = 1'b0;
        ins = cmd_byte(1);
        p1 = cmd_byte(2);
        if (n < 4)
            sw = SW_BAD_LENGTH;
        else if (ins == INS_SELECT && p1 == P1_BY_NAME)
        begin
            sw = SW_NOT_FOUND;
            if (n >= 12 && cmd_byte(4) == 7)
            begin
                same = 1'b1;
                for (int i = 0; i < 7; i++)
                    if (cmd_byte(5 + i) != int'(AID[55 - 8 * i -: 8]))
                        same = 1'b0;
                if (same)
                begin
                    sel_file = SEL_NONE;
                    sw = SW_OK;
                end
            end
        end
        else if (ins == INS_SELECT && p1 == P1_BY_ID)
        begin
            sw = SW_NOT_FOUND;
            if (n >= 7 && cmd_byte(4) == 2)
            begin
                fid = (cmd_byte(5) << 8) | cmd_byte(6);
                if (fid == FID_CC)
                begin
                    sel_file = SEL_CC;
                    sw = SW_OK;
                end
                else if (fid == FID_NDEF)
                begin
                    sel_file = SEL_NDEF;
                    sw = SW_OK;
                end
            end
        end
        else if (ins == INS_READ)
        begin
            off = (cmd_byte(2) << 8) | cmd_byte(3);
            le = (n >= 5 && cmd_byte(4) != 0) ? cmd_byte(4) : 256;
            fsize = (sel_file == SEL_CC) ? 15 : msg_len + 2;
            if (sel_file != SEL_CC && sel_file != SEL_NDEF)
                sw = SW_NO_FILE;
            else if (off >= fsize)
                sw = SW_BAD_OFFSET;
            else
            begin
                take = fsize - off;
                if (take > le)
                    take = le;
                for (int i = 0; i < take; i++)
                begin
                    p = off + i;
                    if (sel_file == SEL_CC)
                        resp.push_back(cap_cont_byte(p));
                    else if (p == 0)
                        resp.push_back(msg_len[15:8]);
                    else if (p == 1)
                        resp.push_back(msg_len[7:0]);
                    else
                        resp.push_back(msg_mem[p - 2]);
                end
                sw = SW_OK;
            end
        end
        else if (ins == INS_UPDATE)
        begin
            off = (cmd_byte(2) << 8) | cmd_byte(3);
            lc = cmd_byte(4);
            if (tag_ro)
                sw = SW_NOT_ALLOWED;
            else if (sel_file != SEL_NDEF)
                sw = SW_NO_FILE;
            else if (n < 5 || lc == 0 || n < 5 + lc)
                sw = SW_BAD_LENGTH;
            else
            begin
                nlen = msg_len & 16'hFFFF;
                for (int i = 0; i < lc; i++)
                begin
                    p = off + i;
                    if (p == 0)
                    begin
                        nlen = (nlen & 8'hFF) | (cmd_byte(5 + i) << 8);
                        touched = 1'b1;
                    end
                    else if (p == 1)
                    begin
                        nlen = (nlen & 16'hFF00) | cmd_byte(5 + i);
                        touched = 1'b1;
                    end
                    else if (p - 2 >= tag_cap)
                        fail = 1'b1;
                end
                if (fail || (touched && nlen > tag_cap))
                    sw = SW_NO_SPACE;
                else
                begin
                    for (int i = 0; i < lc; i++)
                    begin
                        p = off + i;
                        if (p >= 2 && p - 2 < STORE_BYTES)
                            msg_mem[p - 2] = cmd_buf[5 + i];
                    end
                    if (touched)
                    begin
                        msg_len = nlen;
                        commit = 1'b1;
                    end
                    sw = SW_OK;
                end
            end
        end
        else
            sw = SW_BAD_INS;
        resp.push_back(sw[15:8]);
        resp.push_back(sw[7:0]);
    endtask

    // tag behavior for one accepted request
    task automatic tag_accept(input in_t req);
        logic [7:0] resp[$];
        logic [15:0] sw;
        bit commit;
        int n;
        int beats;
        int cnt;
        out_t b;
        case (req.opcode)
            OP_HOST_WR:
                msg_mem[req.host_address] = req.data_byte;
            OP_ACTIVATE:
            begin
                sel_file = SEL_NONE;
                cmd_n = 0;
            end
            OP_APDU:
            begin
                if (cmd_n < CMD_BYTES)
                begin
                    cmd_buf[cmd_n] = req.data_byte;
                    cmd_n++;
                end
                if (req.last_byte)
                begin
                    n = cmd_n;
                    cmd_n = 0;
                    answer_cmd(n, resp, sw, commit);
                    beats = (resp.size() + 7) / 8;
                    for (int k = 0; k < beats; k++)
                    begin
                        b = '0;
                        cnt = resp.size() - 8 * k;
                        if (cnt > 8)
                            cnt = 8;
                        for (int i = 0; i < cnt; i++)
                            b.response_bytes[63 - 8 * i -: 8] = resp[8 * k + i];
                        b.byte_count = cnt;
                        if (k == beats - 1)
                        begin
                            b.last_beat = 1'b1;
                            b.status_word = sw;
                            b.committed = commit;
                            b.committed_length = commit ? msg_len : 0;
                        end
                        beat_q.push_back(b);
                    end
                end
            end
            default:
                ;
        endcase
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    // accepted requests and response checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                tag_accept(in_data);
            if (out_valid && out_ready)
            begin
                if (beat_q.size() == 0)
                    report("unexpected beat", out_data.response_bytes, 0);
                else
                begin
                    out_t w;
                    w = beat_q.pop_front();
                    if (out_data.response_bytes !== w.response_bytes)
                        report("response_bytes", out_data.response_bytes, w.response_bytes);
                    if (out_data.byte_count !== w.byte_count)
                        report("byte_count", out_data.byte_count, w.byte_count);
                    if (out_data.last_beat !== w.last_beat)
                        report("last_beat", out_data.last_beat, w.last_beat);
                    if (out_data.status_word !== w.status_word)
                        report("status_word", out_data.status_word, w.status_word);
                    if (out_data.committed !== w.committed)
                        report("committed", out_data.committed, w.committed);
                    if (out_data.committed_length !== w.committed_length)
                        report("committed_length", out_data.committed_length,
                               w.committed_length);
                end
            end
        end
    end

    // register write while idle, mirrored into the tracked state
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_READ_ONLY:
                tag_ro = v[0];
            REG_CAPACITY:
            begin
                tag_cap = v[12:0];
                if (tag_cap > STORE_BYTES)
                    tag_cap = STORE_BYTES;
                if (msg_len > tag_cap)
                    msg_len = tag_cap;
                gen_cap = tag_cap;
            end
            REG_INIT_LEN:
            begin
                tag_init_len = v[12:0];
                msg_len = (tag_init_len > tag_cap) ? tag_cap : tag_init_len;
            end
            REG_CC_LOW:
                cc_lo = v;
            REG_CC_HIGH:
                cc_hi = v[55:0];
            default:
                ;
        endcase
    endtask

    task automatic host_write(input int addr, input logic [7:0] d);
        in_t r;
        r.opcode = OP_HOST_WR;
        r.data_byte = d;
        r.last_byte = $urandom_range(0, 1);
        r.host_address = addr;
        pending_reqs.push_back(r);
        written[addr] = 1'b1;
    endtask

    task automatic send_apdu(input logic [7:0] bytes[$]);
        in_t r;
        foreach (bytes[i])
        begin
            r.opcode = OP_APDU;
            r.data_byte = bytes[i];
            r.last_byte = (i == bytes.size() - 1);
            r.host_address = $urandom_range(0, 4095);
            pending_reqs.push_back(r);
        end
    endtask

    task automatic send_plain(input logic [1:0] op);
        in_t r;
        r.opcode = op;
        r.data_byte = $urandom_range(0, 255);
        r.last_byte = $urandom_range(0, 1);
        r.host_address = $urandom_range(0, 4095);
        pending_reqs.push_back(r);
    endtask

    // fill every store byte a read at this offset could reach
    task automatic cover_read(input int off, input int le);
        int lo;
        int hi;
        lo = (off < 2) ? 0 : off - 2;
        hi = off - 2 + le;
        if (hi > STORE_BYTES)
            hi = STORE_BYTES;
        for (int m = lo; m < hi; m++)
            if (!written[m])
                host_write(m, $urandom_range(0, 255));
    endtask

    task automatic cmd_select_aid(input bit good);
        logic [7:0] c[$];
        c = '{8'h00, INS_SELECT, P1_BY_NAME, 8'h00, 8'h07};
        for (int i = 0; i < 7; i++)
            c.push_back(AID[55 - 8 * i -: 8]);
        if (!good)
            c[$urandom_range(4, 11)] ^= 8'h01 << $urandom_range(0, 7);
        if ($urandom_range(0, 1))
            c.push_back(8'h00);
        send_apdu(c);
    endtask

    task automatic cmd_select_file(input logic [15:0] fid, input logic [7:0] lc);
        logic [7:0] c[$];
        c = '{8'h00, INS_SELECT, P1_BY_ID, 8'h0C, lc, fid[15:8], fid[7:0]};
        send_apdu(c);
    endtask

    task automatic cmd_read(input int off, input int le, input bit with_le);
        logic [7:0] c[$];
        c = '{8'h00, INS_READ, off[15:8], off[7:0]};
        if (with_le)
            c.push_back(le[7:0]);
        cover_read(off, (with_le && le[7:0] != 0) ? le[7:0] : 256);
        send_apdu(c);
    endtask

    task automatic cmd_update(input int off, input logic [7:0] data[$], input int lc);
        logic [7:0] c[$];
        c = '{8'h00, INS_UPDATE, off[15:8], off[7:0], lc[7:0]};
        foreach (data[i])
            c.push_back(data[i]);
        send_apdu(c);
    endtask

    function automatic int pick_off();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 20);
        if (r < 92)
            return $urandom_range(0, 300);
        return $urandom_range(0, 65535);
    endfunction

    // one random command, mostly well formed
    task automatic random_cmd();
        logic [7:0] d[$];
        int r;
        int off;
        int lc;
        int nl;
        r = $urandom_range(0, 99);
        if (r < 8)
            cmd_select_aid($urandom_range(0, 9) != 0);
        else if (r < 20)
            cmd_select_file(FID_NDEF, 8'h02);
        else if (r < 26)
            cmd_select_file(FID_CC, 8'h02);
        else if (r < 29)
            cmd_select_file($urandom_range(0, 65535), $urandom_range(0, 1) ? 8'h02 : 8'h01);
        else if (r < 55)
        begin
            off = pick_off();
            if (off > 300 && gen_cap > 300 && $urandom_range(0, 3) != 0)
                off = $urandom_range(0, 20);
            cmd_read(off, $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 40),
                     $urandom_range(0, 9) != 0);
        end
        else if (r < 80)
        begin
            off = ($urandom_range(0, 99) < 35) ? $urandom_range(0, 1)
                : ($urandom_range(0, 19) == 0 ? $urandom_range(0, 65535)
                                               : $urandom_range(2, 40));
            lc = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
            for (int i = 0; i < lc; i++)
                d.push_back($urandom_range(0, 255));
            // length byte kept within capacity most of the time
            if (off == 0 && lc >= 2 && $urandom_range(0, 4) != 0)
            begin
                nl = $urandom_range(0, gen_cap);
                d[0] = nl[15:8];
                d[1] = nl[7:0];
            end
            if (lc > 0 && $urandom_range(0, 14) == 0)
                void'(d.pop_back());
            cmd_update(off, d, lc);
        end
        else if (r < 84)
        begin
            lc = $urandom_range(1, 3);
            for (int i = 0; i < lc; i++)
                d.push_back($urandom_range(0, 255));
            send_apdu(d);
        end
        else if (r < 87)
        begin
            d = '{8'h00, 8'h00, 8'h00, 8'h00};
            d[1] = $urandom_range(0, 255);
            if (d[1] == INS_READ || d[1] == INS_UPDATE || d[1] == INS_SELECT)
                d[1] = 8'hCA;
            send_apdu(d);
        end
        else if (r < 90)
        begin
            lc = $urandom_range(0, 5);
            for (int i = 0; i < lc; i++)
                send_plain(OP_APDU);
            if (lc > 0)
                pending_reqs[$].last_byte = 1'b0;
            send_plain(OP_ACTIVATE);
        end
        else if (r < 93)
        begin
            send_plain(OP_UNUSED);
            host_write($urandom_range(0, 4095), $urandom_range(0, 255));
        end
        else
        begin
            lc = $urandom_range(4, 12);
            for (int i = 0; i < lc; i++)
                d.push_back($urandom_range(0, 255));
            // keep unrestricted reads out of noise
            if (d[1] == INS_READ)
                d[1] = 8'hB1;
            send_apdu(d);
        end
    endtask

    task automatic random_phase(input int target);
        int start;
        start = rand_items;
        while (rand_items - start < target)
        begin
            random_cmd();
            rand_items += 4;
        end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || in_valid)
            @(posedge clk);
        while (beat_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // stimulus and configuration sequence
    initial
    begin
        logic [7:0] d[$];
        logic [7:0] big[$];
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        tag_ro = 0;
        tag_cap = 0;
        tag_init_len = 0;
        cc_lo = '0;
        cc_hi = '0;
        msg_len = 0;
        sel_file = SEL_NONE;
        cmd_n = 0;
        gen_cap = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: basic commands and error answers
        write_reg(REG_CAPACITY, 64);
        write_reg(REG_INIT_LEN, 10);
        write_reg(REG_READ_ONLY, 0);
        write_reg(REG_CC_LOW, {$urandom, $urandom});
        write_reg(REG_CC_HIGH, {$urandom, $urandom});
        cmd_read(0, 0, 1'b0);
        send_apdu('{8'h00, INS_READ});
        send_apdu('{8'h00, 8'h12, 8'h00, 8'h00});
        cmd_select_aid(1'b0);
        cmd_select_aid(1'b1);
        cmd_select_file(FID_CC, 8'h02);
        cmd_read(0, 0, 1'b1);
        cmd_read(15, 1, 1'b1);
        cmd_select_file(16'hE105, 8'h02);
        cmd_select_file(FID_NDEF, 8'h02);
        cmd_update(0, '{8'h00, 8'h05}, 2);
        cmd_update(2, '{8'hFF, 8'h00, 8'hA5}, 3);
        cmd_read(0, 0, 1'b1);
        cmd_update(60, '{8'h1, 8'h2, 8'h3, 8'h4, 8'h5, 8'h6, 8'h7, 8'h8}, 8);
        cmd_update(0, '{8'h00, 8'h41}, 2);
        cmd_update(2, d, 0);
        send_apdu('{8'h00, INS_UPDATE, 8'h00, 8'h02});
        send_plain(OP_ACTIVATE);
        cmd_read(0, 4, 1'b1);
        // command longer than the buffer
        cmd_select_file(FID_NDEF, 8'h02);
        big = '{8'h00, INS_READ, 8'h00, 8'h00, 8'h0C};
        for (int i = 0; i < 515; i++)
            big.push_back($urandom_range(0, 255));
        send_apdu(big);
        wait_idle();

        // largest store, receiver held off for a long stretch
        idle_on = 1'b1;
        write_reg(REG_CAPACITY, 4096);
        write_reg(REG_INIT_LEN, 4096);
        write_reg(REG_CC_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_CC_HIGH, 56'hFF_FFFF_FFFF_FFFF);
        cmd_select_file(FID_NDEF, 8'h02);
        cmd_read(4000, 0, 1'b0);
        cmd_read(0, 0, 1'b0);
        cmd_select_file(FID_CC, 8'h02);
        cmd_read(0, 0, 1'b1);
        press_go <= 1'b1;
        random_phase(40);
        wait_idle();

        // read only, no capacity, no idling
        idle_on = 1'b0;
        write_reg(REG_READ_ONLY, 1);
        write_reg(REG_CAPACITY, 0);
        write_reg(REG_INIT_LEN, 0);
        write_reg(REG_CC_LOW, 64'h0);
        write_reg(REG_CC_HIGH, 56'h0);
        random_phase(30);
        wait_idle();

        // oversize values saturate, then a small capacity clamps the length
        idle_on = 1'b1;
        write_reg(REG_READ_ONLY, 0);
        write_reg(REG_CAPACITY, 8191);
        write_reg(REG_INIT_LEN, 8191);
        write_reg(REG_CAPACITY, 24);
        write_reg(REG_CC_LOW, {$urandom, $urandom});
        write_reg(REG_CC_HIGH, {$urandom, $urandom});
        random_phase(60);
        wait_idle();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // overall time limit
    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/t4t_pkg.sv
sv/t4t_decode.sv
sv/type4_tag_apdu_responder_core.sv
test/tb_type4_tag_apdu_responder_core.sv
